// File: rtl/ftw_pkg.sv
// Package: constants and types for the float-to-word converter.
`default_nettype none
package ftw_pkg;
  localparam int unsigned OPERAND_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned RMODE_W = 2;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_PLUS    = 2'd2,
    RM_MINUS   = 2'd3
  } rmode_t;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;

  // Unpacked operand: 53-bit significand, 12-bit exponent biased by 1023
  typedef struct packed {
    logic        neg;
    logic        special;
    logic [52:0] mant;
    logic [11:0] ex;
  } unpack_t;

  typedef struct packed {
    logic        neg;
    logic        special;
    logic [32:0] ip;
    logic        half;
    logic        sticky;
  } align_t;
endpackage
`default_nettype wire

// File: rtl/ftw_stream_if.sv
// Interfaces: valid/ready channels for operands and results.
`default_nettype none
interface ftw_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [63:0] operand;
  modport source (output valid, output operation, output operand, input ready);
  modport sink (input valid, input operation, input operand, output ready);
endinterface

interface ftw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] word_value;
  logic               invalid;
  modport source (output valid, output word_value, output invalid, input ready);
  modport sink (input valid, input word_value, input invalid, output ready);
endinterface
`default_nettype wire

// File: rtl/float_to_word_round_convert_top.sv
// Top level: pipelined IEEE-754 to int32 converter with rounding modes.
//
//   channel | dir | beat contents
//   in_     | in  | operation, operand
//   out_    | out | word_value, invalid
//   cfg_    | in  | rounding_mode (write enable + data)
//
// Four register stages (unpack, align, round, range); one beat per cycle while out_ is not stalled.
// rst_n clears the stage valid bits and sets the rounding mode to nearest even.
// A stall on out_ holds every full stage; bubbles collapse.
`default_nettype none
module float_to_word_round_convert_top (
  input  wire logic clk,
  input  wire logic rst_n,
  ftw_in_if.sink    in_ch,
  ftw_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [ftw_pkg::RMODE_W-1:0] cfg_data
);
  import ftw_pkg::*;

  logic [RMODE_W-1:0] rmode_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;
  unpack_t s1_r, s1_nxt;
  align_t  s2_r, s2_nxt;
  logic        s3_neg_r, s3_bad_r;
  logic [33:0] s3_mag_r;
  logic [33:0] mag_nxt;
  logic        inc;
  logic signed [WORD_W-1:0] s4_val_r, val_nxt;
  logic s4_inv_r, inv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) rmode_r <= RM_NEAREST;
    else if (cfg_we) rmode_r <= cfg_data;
  end

  assign adv4 = !v4_r || out_ch.ready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ch.ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_ch.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // Stage 1: unpack
  always_comb begin
    s1_nxt = '0;
    if (in_ch.operation) begin
      s1_nxt.neg = in_ch.operand[63];
      s1_nxt.special = &in_ch.operand[62:52];
      s1_nxt.mant = {(|in_ch.operand[62:52]), in_ch.operand[51:0]};
      s1_nxt.ex = (|in_ch.operand[62:52]) ? {1'b0, in_ch.operand[62:52]} : 12'd1;
    end else begin
      s1_nxt.neg = in_ch.operand[31];
      s1_nxt.special = &in_ch.operand[30:23];
      s1_nxt.mant = {(|in_ch.operand[30:23]), in_ch.operand[22:0], 29'd0};
      s1_nxt.ex = (|in_ch.operand[30:23]) ? {4'd0, in_ch.operand[30:23]} + 12'd896
                                          : 12'd897;
    end
  end

  always_ff @(posedge clk) if (adv1) s1_r <= s1_nxt;

  // Stage 2: align; significand scaled as 1.52 at exponent ex-1023
  logic [12:0] e_unb;
  logic [84:0] wide;
  logic [6:0]  lsh;
  always_comb begin
    s2_nxt = '0;
    s2_nxt.neg = s1_r.neg;
    e_unb = {1'b0, s1_r.ex} - 13'd1023;
    wide = '0;
    lsh = '0;
    if (s1_r.special || (!e_unb[12] && e_unb[11:0] >= 12'd32)) begin
      s2_nxt.special = 1'b1;
    end else if (e_unb[12] && e_unb < 13'h1FFF) begin
      s2_nxt.ip = '0;
      s2_nxt.half = 1'b0;
      s2_nxt.sticky = |s1_r.mant;
    end else begin
      // e in [-1, 31]: shift left by e+1, integer part at bits 84:53
      lsh = e_unb[6:0] + 7'd1;
      wide = {32'd0, s1_r.mant} << lsh;
      s2_nxt.ip = {1'b0, wide[84:53]};
      s2_nxt.half = wide[52];
      s2_nxt.sticky = |wide[51:0];
    end
  end

  always_ff @(posedge clk) if (adv2) s2_r <= s2_nxt;

  // Stage 3: round
  always_comb begin
    unique case (rmode_t'(rmode_r))
      RM_NEAREST: inc = s2_r.half && (s2_r.sticky || s2_r.ip[0]);
      RM_PLUS:    inc = !s2_r.neg && (s2_r.half || s2_r.sticky);
      RM_MINUS:   inc = s2_r.neg && (s2_r.half || s2_r.sticky);
      default:    inc = 1'b0;
    endcase
    mag_nxt = {1'b0, s2_r.ip} + {33'd0, inc};
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_neg_r <= s2_r.neg;
      s3_bad_r <= s2_r.special;
      s3_mag_r <= mag_nxt;
    end
  end

  // Stage 4: range check and sign
  always_comb begin
    inv_nxt = s3_bad_r ||
              (s3_neg_r && s3_mag_r > {1'b0, NEG_LIMIT}) ||
              (!s3_neg_r && s3_mag_r > {1'b0, POS_LIMIT});
    if (inv_nxt) val_nxt = WORD_MAX;
    else if (s3_neg_r) val_nxt = 32'd0 - s3_mag_r[31:0];
    else val_nxt = s3_mag_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_val_r <= val_nxt;
      s4_inv_r <= inv_nxt;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.word_value = s4_val_r;
  assign out_ch.invalid = s4_inv_r;
endmodule
`default_nettype wire

// File: rtl/ftw_checker.sv
// Checker: port-level properties of the converter, bound to the top level.
`default_nettype none
module ftw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] out_word_value,
  input wire logic out_invalid
);
  a_inv_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_word_value == 32'h7FFF_FFFF)
    else $error("invalid beat without saturated value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word_value))
    else $error("stalled result changed");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind float_to_word_round_convert_top ftw_checker u_ftw_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_word_value(out_ch.word_value), .out_invalid(out_ch.invalid)
);
`default_nettype wire
